// File: hw/rtl/pbpe_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// Poisson-binomial PMF engine. No dependencies.
`default_nettype none

package pbpe_pkg;

   // Store geometry and number format
   localparam int MAX_ENTRIES    = 1024;
   localparam int PROB_FRAC_BITS = 16;
   localparam int ADDR_W         = $clog2(MAX_ENTRIES);
   localparam int VALUE_W        = PROB_FRAC_BITS + 1;
   localparam int PROD_W         = 2 * VALUE_W;
   localparam int INDEX_W        = 10;
   localparam int COUNT_W        = 10;
   localparam int STATUS_W       = 2;

   localparam logic [VALUE_W-1:0] ONE_FX  = VALUE_W'(1) << PROB_FRAC_BITS;
   localparam logic [PROD_W-1:0]  HALF_FX = PROD_W'(1) << (PROB_FRAC_BITS - 1);

   // Request function codes
   localparam logic FUNC_FOLD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // Controller -> datapath commands
   typedef struct packed {
      logic                load_prob;    // latch clamped p and 1-p
      logic                init_lo;      // write 1-p to entry 0, terms = 1
      logic                init_hi;      // write p to entry 1
      logic                sweep_arm;    // clear sweep counter and lower neighbor
      logic                sweep_issue;  // read next entry into the sweep pipe
      logic                read_issue;   // read entry_index for a read request
      logic                rsp_load;     // load the response register
      logic                rsp_from_mem; // response value from read data
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic is_read;
      logic fold_start;
      logic fold_full;
      logic read_ok;
      logic last_issue;
      logic sweep_done;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/pbpe_req_if.sv
// Request channel: valid/ready handshake with the fold/read payload.
// Depends on pbpe_pkg for field widths.
`default_nettype none

interface pbpe_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [pbpe_pkg::VALUE_W-1:0] prob;
   logic                        start_series;
   logic [pbpe_pkg::INDEX_W-1:0] entry_index;

   modport source (output valid, output func, output prob, output start_series,
                   output entry_index, input ready);
   modport sink   (input valid, input func, input prob, input start_series,
                   input entry_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pbpe_rsp_if.sv
// Response channel: valid/ready handshake with the PMF value, term count, status.
// Depends on pbpe_pkg for field widths.
`default_nettype none

interface pbpe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pbpe_pkg::VALUE_W-1:0]  pmf_value;
   logic [pbpe_pkg::COUNT_W-1:0]  term_count;
   logic [pbpe_pkg::STATUS_W-1:0] status;

   modport source (output valid, output pmf_value, output term_count,
                   output status, input ready);
   modport sink   (input valid, input pmf_value, input term_count,
                   input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pbpe_ctrl.sv
// Sequencing state machine: decodes each request and steps the datapath
// through init, sweep and reply. Depends on pbpe_pkg.
`default_nettype none

module pbpe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pbpe_pkg::sts_type sts,
   output pbpe_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_INIT   = 6'b000010,
      ST_RDWAIT = 6'b000100,
      ST_SWEEP  = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_REPLY  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Take a request only when idle and the response slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && !sts.rsp_busy;
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.is_read) begin
                  if (sts.read_ok) begin
                     cmd.read_issue = 1'b1;
                     state_in       = ST_RDWAIT;
                  end else begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = pbpe_pkg::STAT_RANGE;
                  end
               end else if (sts.fold_start) begin
                  cmd.load_prob = 1'b1;
                  cmd.init_lo   = 1'b1;
                  state_in      = ST_INIT;
               end else if (sts.fold_full) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = pbpe_pkg::STAT_FULL;
               end else begin
                  cmd.load_prob = 1'b1;
                  cmd.sweep_arm = 1'b1;
                  state_in      = ST_SWEEP;
               end
            end
         end
         ST_INIT: begin
            cmd.init_hi = 1'b1;
            state_in    = ST_REPLY;
         end
         ST_RDWAIT: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_from_mem = 1'b1;
            cmd.rsp_status   = pbpe_pkg::STAT_OK;
            state_in         = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep_issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.sweep_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = pbpe_pkg::STAT_OK;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pbpe_dpath.sv
// PMF store, term counter, three-stage convolution sweep pipe and the
// response register. Depends on pbpe_pkg and pbpe_rsp_if.
`default_nettype none

module pbpe_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pbpe_pkg::cmd_type             cmd,
   output pbpe_pkg::sts_type                  sts,
   input  wire logic                          req_func,
   input  wire logic [pbpe_pkg::VALUE_W-1:0]  req_prob,
   input  wire logic                          req_start_series,
   input  wire logic [pbpe_pkg::INDEX_W-1:0]  req_entry_index,
   pbpe_rsp_if.source                         rsp
);

   localparam int AW = pbpe_pkg::ADDR_W;
   localparam int VW = pbpe_pkg::VALUE_W;
   localparam int PW = pbpe_pkg::PROD_W;
   localparam int FB = pbpe_pkg::PROB_FRAC_BITS;

   // PMF store
   logic [VW-1:0] mem [pbpe_pkg::MAX_ENTRIES];
   logic [VW-1:0] rdata_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [VW-1:0] wr_data;
   logic          wr_en;

   // Series state and latched probability
   logic [AW-1:0] terms_ff, terms_in;
   logic [VW-1:0] p_ff, q_ff;
   logic [VW-1:0] p_clamp, q_new;
   logic [AW-1:0] len;

   // Sweep pipe
   logic [AW-1:0] sweep_ff;
   logic          s1_vld_ff, s1_top_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [VW-1:0] lower_ff;
   logic [VW-1:0] cur;
   logic          s2_vld_ff, s2_top_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [PW-1:0] prod_p_ff, prod_q_ff;
   logic [PW-1:0] rnd_p_w, rnd_q_w;
   logic [VW:0]   sum;
   logic [VW-1:0] sum_sat;

   // Response register
   logic                          rsp_valid_ff;
   logic [VW-1:0]                 rsp_value_ff;
   logic [pbpe_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [pbpe_pkg::STATUS_W-1:0] rsp_status_ff;

   function automatic logic [pbpe_pkg::INDEX_W-1:0] INDEX_W_EXT(input logic [AW-1:0] v);
      return pbpe_pkg::INDEX_W'(v);
   endfunction

   // Probability clamp and complement
   assign p_clamp = (req_prob > pbpe_pkg::ONE_FX) ? pbpe_pkg::ONE_FX : req_prob;
   assign q_new   = pbpe_pkg::ONE_FX - p_clamp;

   // Current PMF length is terms + 1 while a series exists
   assign len = terms_ff + AW'(1);

   // Request decode for the controller
   assign sts.is_read    = (req_func == pbpe_pkg::FUNC_READ);
   assign sts.fold_start = req_start_series || (terms_ff == '0);
   assign sts.fold_full  = (terms_ff >= AW'(pbpe_pkg::MAX_ENTRIES - 1)) &&
                           (terms_ff != '0) && !req_start_series;
   assign sts.read_ok    = (terms_ff != '0) &&
                           ({1'b0, req_entry_index} <= {1'b0, INDEX_W_EXT(terms_ff)});
   assign sts.last_issue = (sweep_ff == len);
   assign sts.sweep_done = s2_vld_ff && s2_top_ff;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp.ready;

   // Store ports
   assign rd_addr = cmd.read_issue ? AW'(req_entry_index) : sweep_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s2_addr_ff;
      wr_data = sum_sat;
      if (cmd.init_lo) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = q_new;
      end else if (cmd.init_hi) begin
         wr_en   = 1'b1;
         wr_addr = AW'(1);
         wr_data = p_ff;
      end else if (s2_vld_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Probability latch
   always_ff @(posedge clock) begin
      if (cmd.load_prob) begin
         p_ff <= p_clamp;
         q_ff <= q_new;
      end
   end

   // Term count
   always_comb begin
      terms_in = terms_ff;
      if (cmd.init_lo) begin
         terms_in = AW'(1);
      end else if (sts.sweep_done) begin
         terms_in = terms_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff <= '0;
      end else begin
         terms_ff <= terms_in;
      end
   end

   // Stage 0: issue reads for entries 0..len
   always_ff @(posedge clock) begin
      if (cmd.sweep_arm) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_issue) begin
         sweep_ff <= sweep_ff + AW'(1);
      end
      s1_addr_ff <= sweep_ff;
      s1_top_ff  <= (sweep_ff == len);
   end

   // Stage 1: the entry past the end reads as zero; form both products
   assign cur = s1_top_ff ? '0 : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.sweep_arm) begin
         lower_ff <= '0;
      end else if (s1_vld_ff) begin
         lower_ff <= cur;
      end
      prod_p_ff  <= PW'(p_ff) * PW'(lower_ff);
      prod_q_ff  <= PW'(q_ff) * PW'(cur);
      s2_addr_ff <= s1_addr_ff;
      s2_top_ff  <= s1_top_ff;
   end

   // Stage 2: round each product to nearest, add, saturate at one
   assign rnd_p_w = prod_p_ff + pbpe_pkg::HALF_FX;
   assign rnd_q_w = prod_q_ff + pbpe_pkg::HALF_FX;
   assign sum     = {1'b0, rnd_p_w[FB +: VW]} + {1'b0, rnd_q_w[FB +: VW]};
   assign sum_sat = (sum > {1'b0, pbpe_pkg::ONE_FX}) ? pbpe_pkg::ONE_FX : sum[VW-1:0];

   // Pipe valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.sweep_issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_value_ff  <= cmd.rsp_from_mem ? rdata_ff : '0;
         rsp_count_ff  <= pbpe_pkg::COUNT_W'(terms_ff);
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pmf_value  = rsp_value_ff;
   assign rsp.term_count = rsp_count_ff;
   assign rsp.status     = rsp_status_ff;

   // A new response never overwrites one that has not been taken
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response register overwritten before it was taken");

   // Finishing a sweep grows the series by exactly one term
   a_sweep_grows: assert property (@(posedge clock) disable iff (reset)
      sts.sweep_done |=> (terms_ff == AW'($past(terms_ff) + AW'(1))))
      else $error("sweep completion did not advance the term count");

   // Sweep writes stay inside the new PMF length
   a_sweep_in_len: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (s2_addr_ff <= len))
      else $error("sweep write beyond the PMF length");

endmodule

`default_nettype wire

// File: hw/rtl/poisson_binomial_pmf_engine_unit.sv
// Top level of the Poisson-binomial PMF engine: joins the sequencer and the
// datapath. Depends on pbpe_pkg, pbpe_req_if, pbpe_rsp_if, pbpe_ctrl, pbpe_dpath.
//
// One request is in flight at a time and each gives exactly one response. A
// fold that continues a series sweeps all L = term_count + 1 stored entries
// through a store with one read and one write port and a three-stage
// multiply/round/saturate pipe, one entry per cycle. A fold that starts a
// series writes two entries; a read answers from the registered store data;
// a dropped fold or an out-of-range read answers in the next cycle. A new
// request is taken as soon as the block is idle and the response register is
// empty or being drained.
`default_nettype none

module poisson_binomial_pmf_engine_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   pbpe_req_if.sink   req_bus,
   pbpe_rsp_if.source rsp_bus
);

   pbpe_pkg::cmd_type cmd;
   pbpe_pkg::sts_type sts;
   logic              ready;

   // Sequencer
   pbpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_bus.ready = ready;

   // Store, sweep pipe and response register
   pbpe_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_bus.func),
      .req_prob         (req_bus.prob),
      .req_start_series (req_bus.start_series),
      .req_entry_index  (req_bus.entry_index),
      .rsp              (rsp_bus)
   );

endmodule

`default_nettype wire

// File: tb/sv/poisson_binomial_pmf_engine_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for poisson_binomial_pmf_engine_unit: drives fold and read
// requests, predicts every response from a shadow PMF store and checks them in order.
// Depends on pbpe_pkg, pbpe_req_if, pbpe_rsp_if and the engine RTL.

module poisson_binomial_pmf_engine_unit_tb;
   import pbpe_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [VALUE_W-1:0] PROB_ALL_ONES = '1;

   typedef struct packed {
      logic                func;
      logic [VALUE_W-1:0]  prob;
      logic                start_series;
      logic [INDEX_W-1:0]  entry_index;
   } pmf_req_t;

   typedef struct packed {
      logic [VALUE_W-1:0]  pmf_value;
      logic [COUNT_W-1:0]  term_count;
      logic [STATUS_W-1:0] status;
   } pmf_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbpe_req_if req_bus ();
   pbpe_rsp_if rsp_bus ();

   poisson_binomial_pmf_engine_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the engine state
   logic [VALUE_W-1:0] pmf_shadow [MAX_ENTRIES];
   int unsigned        folded_shadow = 0;

   pmf_rsp_t expected_rsps [$];
   int       error_count   = 0;
   int       send_idle_pct = 0;
   int       rsp_stall_pct = 0;
   int       hold_request  = 0;
   int       quiet_cycles  = 0;

   always #1 clock = ~clock;

   // p * x in Q1.16, half rounds up
   function automatic logic [VALUE_W-1:0] scale_round(input logic [VALUE_W-1:0] a,
                                                      input logic [VALUE_W-1:0] b);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(a) * PROD_W'(b) + HALF_FX;
      return prod[PROB_FRAC_BITS +: VALUE_W];
   endfunction

   function automatic logic [VALUE_W-1:0] sum_clip(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, ONE_FX}) ? ONE_FX : s[VALUE_W-1:0];
   endfunction

   // Update the shadow PMF with one accepted request and return its response
   function automatic pmf_rsp_t apply_request(input pmf_req_t r);
      pmf_rsp_t           rsp;
      logic [VALUE_W-1:0] p, q, lower, cur;
      int unsigned        len, j;
      rsp.pmf_value = '0;
      rsp.status    = STAT_OK;
      if (r.func == FUNC_FOLD) begin
         p = (r.prob > ONE_FX) ? ONE_FX : r.prob;
         q = ONE_FX - p;
         if (r.start_series || folded_shadow == 0) begin
            pmf_shadow[0] = q;
            pmf_shadow[1] = p;
            folded_shadow = 1;
         end else if (folded_shadow + 2 > MAX_ENTRIES) begin
            rsp.status = STAT_FULL;
         end else begin
            len   = folded_shadow + 1;
            lower = pmf_shadow[0];
            pmf_shadow[len] = scale_round(p, pmf_shadow[len-1]);
            pmf_shadow[0]   = scale_round(q, lower);
            for (j = 1; j < len; j++) begin
               cur           = pmf_shadow[j];
               pmf_shadow[j] = sum_clip(scale_round(p, lower), scale_round(q, cur));
               lower         = cur;
            end
            folded_shadow++;
         end
      end else begin
         len = (folded_shadow != 0) ? folded_shadow + 1 : 0;
         if (r.entry_index >= len)
            rsp.status = STAT_RANGE;
         else
            rsp.pmf_value = pmf_shadow[r.entry_index];
      end
      rsp.term_count = COUNT_W'(folded_shadow);
      return rsp;
   endfunction

   // mostly in [0, 1.0], with the edges and over-range codes mixed in
   function automatic logic [VALUE_W-1:0] random_prob();
      case ($urandom_range(9))
         0:       return '0;
         1:       return ONE_FX;
         2:       return VALUE_W'($urandom_range(ONE_FX + 1, PROB_ALL_ONES));
         default: return VALUE_W'($urandom_range(ONE_FX));
      endcase
   endfunction

   // Offer one request, wait for the handshake, record its expected response.
   // valid is only lowered when a gap follows, so it never toggles in one step.
   task automatic send_request(input pmf_req_t r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= r.func;
      req_bus.prob         <= r.prob;
      req_bus.start_series <= r.start_series;
      req_bus.entry_index  <= r.entry_index;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsps.push_back(apply_request(r));
   endtask

   task automatic send_fold(input logic [VALUE_W-1:0] prob, input logic start);
      pmf_req_t r;
      r.func         = FUNC_FOLD;
      r.prob         = prob;
      r.start_series = start;
      r.entry_index  = INDEX_W'($urandom);
      send_request(r);
   endtask

   task automatic send_read(input logic [INDEX_W-1:0] idx);
      pmf_req_t r;
      r.func         = FUNC_READ;
      r.prob         = VALUE_W'($urandom);
      r.start_series = 1'($urandom_range(1));
      r.entry_index  = idx;
      send_request(r);
   endtask

   // Edge values, both functions, saturation, implicit start, range errors
   task automatic test_directed_basics();
      int i;
      send_read('0);                       // no series yet
      send_read('1);
      send_fold(17'h08000, 1'b0);          // continue without a series starts one
      send_read(0);
      send_read(1);
      send_read(2);                        // one past the end
      send_fold(17'h00000, 1'b0);
      send_fold(ONE_FX, 1'b0);
      send_fold(PROB_ALL_ONES, 1'b0);      // above 1.0, clamped
      send_fold(17'h00001, 1'b0);
      send_fold(17'h0FFFF, 1'b0);
      for (i = 0; i <= 7; i++)
         send_read(INDEX_W'(i));
      send_fold(PROB_ALL_ONES, 1'b1);      // restart with clamped p
      send_read(0);
      send_read(1);
      send_fold(17'h08001, 1'b0);
      send_read(1);
   endtask

   // Grow one series to the full store, then try to go past it
   task automatic test_store_full();
      int i;
      send_fold(VALUE_W'($urandom_range(ONE_FX)), 1'b1);
      for (i = 1; i < MAX_ENTRIES - 1; i++)
         send_fold(random_prob(), 1'b0);
      send_fold(random_prob(), 1'b0);      // dropped: store full
      send_read(INDEX_W'(MAX_ENTRIES - 1));
      send_read(0);
      send_fold(random_prob(), 1'b0);      // still full
      send_fold(random_prob(), 1'b1);      // a start is always taken
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_fold(random_prob(), 1'b1);
      send_fold(random_prob(), 1'b0);
      hold_request = HOLD_CYCLES;
      for (i = 0; i < 10; i++) begin
         if (i % 3 == 0)
            send_fold(random_prob(), 1'b0);
         else
            send_read(INDEX_W'($urandom_range(folded_shadow + 1)));
      end
   endtask

   // Random series of folds with reads mixed in; a few long series, some noise
   task automatic test_random_mix(input int n_items, input int idle_pct, input int stall_pct);
      int sent, series_len, k;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         series_len = ($urandom_range(15) == 0) ? $urandom_range(60, 160)
                                                : $urandom_range(1, 20);
         for (k = 0; k < series_len && sent < n_items; k++) begin
            if (k == 0)
               send_fold(random_prob(), $urandom_range(9) != 0);
            else
               send_fold(random_prob(), $urandom_range(39) == 0);
            sent++;
            while (sent < n_items && $urandom_range(99) < 40) begin
               if ($urandom_range(4) == 0)
                  send_read(INDEX_W'($urandom));
               else
                  send_read(INDEX_W'($urandom_range(folded_shadow)));
               sent++;
            end
         end
      end
   endtask

   // Response ready: random stalls, or a counted hold-off when requested
   initial begin : rsp_ready_driver
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin : rsp_checker
      pmf_rsp_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, value %h count %0d status %0d",
                     $time, rsp_bus.pmf_value, rsp_bus.term_count, rsp_bus.status);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_bus.pmf_value !== want.pmf_value) begin
               error_count++;
               $display("%0t: pmf_value expected %h actual %h",
                        $time, want.pmf_value, rsp_bus.pmf_value);
            end
            if (rsp_bus.term_count !== want.term_count) begin
               error_count++;
               $display("%0t: term_count expected %0d actual %0d",
                        $time, want.term_count, rsp_bus.term_count);
            end
            if (rsp_bus.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
            end
         end
      end
   end

   // Watchdog: too long without a handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("poisson_binomial_pmf_engine_unit_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.func         <= FUNC_FOLD;
      req_bus.prob         <= '0;
      req_bus.start_series <= 1'b0;
      req_bus.entry_index  <= '0;
      reset                <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_store_full();
      test_backpressure();
      test_random_mix(145, 0, 0);
      test_random_mix(145, 52, 0);
      test_random_mix(145, 0, 52);
      test_random_mix(145, 26, 26);

      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("poisson_binomial_pmf_engine_unit_tb: done, clean");
      else
         $display("poisson_binomial_pmf_engine_unit_tb: done, errors");
      $finish;
   end

endmodule

// File: poisson_binomial_pmf_engine_unit.f
hw/rtl/pbpe_pkg.sv
hw/rtl/pbpe_req_if.sv
hw/rtl/pbpe_rsp_if.sv
hw/rtl/pbpe_ctrl.sv
hw/rtl/pbpe_dpath.sv
hw/rtl/poisson_binomial_pmf_engine_unit.sv
tb/sv/poisson_binomial_pmf_engine_unit_tb.sv
